// ===== hdl/oht_pkg.sv =====
`timescale 1ns / 1ps
package oht_pkg;

  localparam int LEVELS = 256;
  localparam int PIX_W  = 8;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_ACCUM,
    ST_DRAIN,
    ST_START,
    ST_RD,
    ST_ACC,
    ST_CHK,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CMP,
    ST_NEXT,
    ST_CLR_TOP,
    ST_DONE
  } state_t;

  // Order of the products taken for one sweep point
  typedef enum logic [2:0] {
    OP_P,
    OP_Q,
    OP_D,
    OP_DEN,
    OP_L,
    OP_R
  } mul_op_t;

  typedef struct packed {
    logic    init_clear;
    logic    accept;
    logic    sweep_start;
    logic    sweep_rd;
    logic    sweep_acc;
    logic    mul_start;
    logic    mul_store;
    logic    cmp_upd;
    logic    t_next;
    logic    clr_top;
    mul_op_t mul_op;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic skip;
    logic mul_done;
    logic t_last;
  } sts_t;

endpackage

// ===== hdl/oht_ram.sv =====
`timescale 1ns / 1ps
module oht_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/oht_mul.sv =====
`timescale 1ns / 1ps
module oht_mul #(
  parameter int AW = 64,
  parameter int BW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [AW-1:0] product
);

  logic          run;
  logic [AW-1:0] acc;
  logic [AW-1:0] ash;
  logic [BW-1:0] bsh;

  // Shift-add, one multiplier bit a cycle; stop once no set bit is left
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc <= '0;
        ash <= a;
        bsh <= b;
        run <= 1'b1;
      end else if (run) begin
        if (bsh == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          if (bsh[0]) begin
            acc <= acc + ash;
          end
          ash <= ash << 1;
          bsh <= bsh >> 1;
        end
      end
    end
  end

  assign product = acc;

endmodule

// ===== hdl/oht_ctrl.sv =====
`timescale 1ns / 1ps
module oht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output oht_pkg::cmd_t cmd,
  input  oht_pkg::sts_t sts
);

  oht_pkg::state_t  state, state_next;
  oht_pkg::mul_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oht_pkg::ST_INIT;
      op    <= oht_pkg::OP_P;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      oht_pkg::ST_INIT: begin
        if (sts.init_done) begin
          state_next = oht_pkg::ST_ACCUM;
        end
      end
      oht_pkg::ST_ACCUM: begin
        if (in_valid && last) begin
          state_next = oht_pkg::ST_DRAIN;
        end
      end
      oht_pkg::ST_DRAIN:   state_next = oht_pkg::ST_START;
      oht_pkg::ST_START:   state_next = oht_pkg::ST_RD;
      oht_pkg::ST_RD:      state_next = oht_pkg::ST_ACC;
      oht_pkg::ST_ACC:     state_next = oht_pkg::ST_CHK;
      oht_pkg::ST_CHK: begin
        op_next = oht_pkg::OP_P;
        state_next = sts.skip ? oht_pkg::ST_NEXT : oht_pkg::ST_MUL_GO;
      end
      oht_pkg::ST_MUL_GO:  state_next = oht_pkg::ST_MUL_WAIT;
      oht_pkg::ST_MUL_WAIT: begin
        if (sts.mul_done) begin
          case (op)
            oht_pkg::OP_P:   op_next = oht_pkg::OP_Q;
            oht_pkg::OP_Q:   op_next = oht_pkg::OP_D;
            oht_pkg::OP_D:   op_next = oht_pkg::OP_DEN;
            oht_pkg::OP_DEN: op_next = oht_pkg::OP_L;
            oht_pkg::OP_L:   op_next = oht_pkg::OP_R;
            default:         op_next = oht_pkg::OP_P;
          endcase
          state_next = (op == oht_pkg::OP_R) ? oht_pkg::ST_CMP : oht_pkg::ST_MUL_GO;
        end
      end
      oht_pkg::ST_CMP:     state_next = oht_pkg::ST_NEXT;
      oht_pkg::ST_NEXT: begin
        state_next = sts.t_last ? oht_pkg::ST_CLR_TOP : oht_pkg::ST_RD;
      end
      oht_pkg::ST_CLR_TOP: state_next = oht_pkg::ST_DONE;
      oht_pkg::ST_DONE: begin
        if (!out_stall) begin
          state_next = oht_pkg::ST_ACCUM;
        end
      end
      default:             state_next = oht_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = op;
    in_stall   = (state != oht_pkg::ST_ACCUM);
    out_valid  = (state == oht_pkg::ST_DONE);
    case (state)
      oht_pkg::ST_INIT:     cmd.init_clear  = 1'b1;
      oht_pkg::ST_ACCUM:    cmd.accept      = in_valid;
      oht_pkg::ST_START:    cmd.sweep_start = 1'b1;
      oht_pkg::ST_RD:       cmd.sweep_rd    = 1'b1;
      oht_pkg::ST_ACC:      cmd.sweep_acc   = 1'b1;
      oht_pkg::ST_MUL_GO:   cmd.mul_start   = 1'b1;
      oht_pkg::ST_MUL_WAIT: cmd.mul_store   = sts.mul_done;
      oht_pkg::ST_CMP:      cmd.cmp_upd     = 1'b1;
      oht_pkg::ST_NEXT:     cmd.t_next      = 1'b1;
      oht_pkg::ST_CLR_TOP:  cmd.clr_top     = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/oht_dp.sv =====
`timescale 1ns / 1ps
module oht_dp #(
  parameter int COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [oht_pkg::PIX_W-1:0] pixel,
  output logic [oht_pkg::PIX_W-1:0] threshold,
  input  oht_pkg::cmd_t             cmd,
  output oht_pkg::sts_t             sts
);

  localparam int W    = COUNT_BITS;
  localparam int PXW  = oht_pkg::PIX_W;
  localparam int NW   = W + PXW;
  localparam int SW   = W + 2 * PXW;
  localparam int PW   = SW + NW;
  localparam int NUMW = 2 * PW;
  localparam int DENW = 2 * NW;
  localparam int CMPW = NUMW + DENW;

  // Histogram memory
  logic           we;
  logic [PXW-1:0] waddr, raddr;
  logic [W-1:0]   wdata, rdata;

  oht_ram #(.WIDTH(W), .DEPTH(oht_pkg::LEVELS)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Increment stage and one-deep forward of the last write
  logic           s2_valid;
  logic [PXW-1:0] s2_addr;
  logic           wq_valid;
  logic [PXW-1:0] wq_addr;
  logic [W-1:0]   wq_data;
  logic [W-1:0]   old_cnt, new_cnt;
  logic           inc;

  logic [PXW-1:0] clr_idx;
  logic [NW-1:0]  n, wb, wf;
  logic [SW-1:0]  s, sb;
  logic [PXW-1:0] t, tm1;
  logic [NW-1:0]  bin_wsum;

  logic [PW-1:0]   p, q, d;
  logic [NUMW-1:0] num, best_num;
  logic [DENW-1:0] den, best_den;
  logic [CMPW-1:0] lhs;
  logic [PXW-1:0]  best_t;

  logic            mul_done;
  logic [CMPW-1:0] mul_a, product;
  logic [PW-1:0]   mul_b;

  assign old_cnt = (wq_valid && (wq_addr == s2_addr)) ? wq_data : rdata;
  assign inc     = (old_cnt != {W{1'b1}});
  assign new_cnt = inc ? old_cnt + W'(1) : old_cnt;

  assign tm1      = t - PXW'(1);
  assign bin_wsum = NW'(rdata) * NW'(tm1);
  assign wf       = n - wb;
  assign d        = (p >= q) ? p - q : q - p;

  always_comb begin
    raddr = cmd.accept ? pixel : tm1;
    we    = 1'b0;
    waddr = s2_addr;
    wdata = new_cnt;
    if (s2_valid) begin
      we = 1'b1;
    end else if (cmd.init_clear) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (cmd.sweep_rd) begin
      // zero each bin as the sweep reads it
      we    = 1'b1;
      waddr = tm1;
      wdata = '0;
    end else if (cmd.clr_top) begin
      we    = 1'b1;
      waddr = {PXW{1'b1}};
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      wq_valid <= 1'b0;
      clr_idx  <= '0;
      n        <= '0;
      s        <= '0;
    end else begin
      s2_valid <= cmd.accept;
      wq_valid <= s2_valid;
      if (cmd.init_clear) begin
        clr_idx <= clr_idx + PXW'(1);
      end
      if (s2_valid && inc) begin
        n <= n + NW'(1);
        s <= s + SW'(s2_addr);
      end else if (cmd.clr_top) begin
        n <= '0;
        s <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s2_addr <= pixel;
    end
    wq_addr <= s2_addr;
    wq_data <= new_cnt;
    if (cmd.sweep_start) begin
      t        <= PXW'(1);
      wb       <= '0;
      sb       <= '0;
      best_num <= '0;
      best_den <= DENW'(1);
      best_t   <= '0;
    end
    if (cmd.sweep_acc) begin
      wb <= wb + NW'(rdata);
      sb <= sb + SW'(bin_wsum);
    end
    if (cmd.t_next) begin
      t <= t + PXW'(1);
    end
    if (cmd.mul_store) begin
      case (cmd.mul_op)
        oht_pkg::OP_P:   p   <= product[PW-1:0];
        oht_pkg::OP_Q:   q   <= product[PW-1:0];
        oht_pkg::OP_D:   num <= product[NUMW-1:0];
        oht_pkg::OP_DEN: den <= product[DENW-1:0];
        oht_pkg::OP_L:   lhs <= product;
        default: begin
        end
      endcase
    end
    // strict compare keeps the earliest maximum
    if (cmd.cmp_upd && (lhs > product)) begin
      best_num <= num;
      best_den <= den;
      best_t   <= t;
    end
  end

  always_comb begin
    case (cmd.mul_op)
      oht_pkg::OP_P: begin
        mul_a = CMPW'(sb);
        mul_b = PW'(n);
      end
      oht_pkg::OP_Q: begin
        mul_a = CMPW'(s);
        mul_b = PW'(wb);
      end
      oht_pkg::OP_D: begin
        mul_a = CMPW'(d);
        mul_b = d;
      end
      oht_pkg::OP_DEN: begin
        mul_a = CMPW'(wb);
        mul_b = PW'(wf);
      end
      oht_pkg::OP_L: begin
        mul_a = CMPW'(num);
        mul_b = PW'(best_den);
      end
      default: begin
        mul_a = CMPW'(best_num);
        mul_b = PW'(den);
      end
    endcase
  end

  oht_mul #(.AW(CMPW), .BW(PW)) u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(product)
  );

  assign sts.init_done = cmd.init_clear && (clr_idx == {PXW{1'b1}});
  assign sts.skip      = (wb == '0) || (wf == '0);
  assign sts.mul_done  = mul_done;
  assign sts.t_last    = (t == {PXW{1'b1}});
  assign threshold     = best_t;

endmodule

// ===== hdl/otsu_histogram_threshold.sv =====
`timescale 1ns / 1ps
// Channel  Signals                         Direction
// input    in_valid, in_stall, pixel, last  request in, stall out
// output   out_valid, out_stall, threshold  request out, stall in
//
// Pixels are taken one per cycle, while in_stall is low, into the histogram RAM; a repeat
// of the same gray level in back-to-back cycles is forwarded around the RAM read.
// After the pixel marked last, the threshold sweep reads one bin per step and
// runs up to six shift-add products per sweep point on one serial multiplier.
// Each product shifts and adds over its second operand up to its highest set bit; a point
// with an empty class on either side skips the products. The sweep covers 255 points.
// After reset the histogram RAM is cleared with in_stall high.
// in_stall stays high from the last pixel until the threshold request is taken.
module otsu_histogram_threshold #(
  parameter int COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [oht_pkg::PIX_W-1:0] pixel,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [oht_pkg::PIX_W-1:0] threshold
);

  oht_pkg::cmd_t cmd;
  oht_pkg::sts_t sts;

  oht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .last(last), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  oht_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .pixel(pixel), .threshold(threshold), .cmd(cmd), .sts(sts)
  );

endmodule

// ===== tb/otsu_histogram_threshold_tb.sv =====
`timescale 1ns / 1ps
module otsu_histogram_threshold_tb;

  localparam int PIX_W      = oht_pkg::PIX_W;
  localparam int LEVELS     = oht_pkg::LEVELS;
  localparam int COUNT_W    = 20;
  localparam int RAND_PIX   = 1700;
  localparam int STALL_LIMIT = 600000;
  localparam int LONG_HOLD  = 3000;
  localparam int END_WAIT   = 200;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    logic [PIX_W-1:0] gray;
    logic             eof;
    logic             drain_first;
  } pix_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] pixel = '0;
  logic             last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] threshold;

  pix_req_t         pix_queue[$];
  logic [PIX_W-1:0] thr_expected[$];
  logic [COUNT_W-1:0] hist [LEVELS];
  logic [COUNT_W-1:0] pix_count;

  logic in_taken = 1'b0;
  int   total_reqs;
  int   pix_taken;
  int   frames_done;
  int   mismatches;
  int   idle_cycles;
  int   hold_left;
  bit   hold_done;

  otsu_histogram_threshold #(.COUNT_BITS(COUNT_W)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .threshold(threshold)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sweep t = 1..255, exact cross-multiplied compare of between-class variance
  function automatic logic [PIX_W-1:0] otsu_pick();
    logic [63:0]  n, s, wb, sb, wf;
    logic [319:0] p, q, d, num, den, best_num, best_den, lhs, rhs;
    logic [PIX_W-1:0] best_t;
    n = 0; s = 0; wb = 0; sb = 0;
    best_num = 0; best_den = 1; best_t = 0;
    for (int t = 0; t < LEVELS; t++) begin
      n += hist[t];
      s += 64'(hist[t]) * t;
    end
    for (int t = 1; t < LEVELS; t++) begin
      wb += hist[t-1];
      sb += 64'(hist[t-1]) * (t - 1);
      wf = n - wb;
      if (wb != 0 && wf != 0) begin
        p = 320'(sb) * 320'(n);
        q = 320'(s) * 320'(wb);
        d = (p >= q) ? p - q : q - p;
        num = d * d;
        den = 320'(wb) * 320'(wf);
        lhs = num * best_den;
        rhs = best_num * den;
        if (lhs > rhs) begin
          best_num = num;
          best_den = den;
          best_t = t[PIX_W-1:0];
        end
      end
    end
    return best_t;
  endfunction

  function automatic int sender_idle_pct();
    if (pix_taken < total_reqs / 3) return 11;
    if (pix_taken < 2 * total_reqs / 3) return 70;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (pix_taken < total_reqs / 3) return 70;
    if (pix_taken < 2 * total_reqs / 3) return 11;
    return 0;
  endfunction

  task automatic add_frame(int len, int lo, int span, bit drain);
    pix_req_t r;
    int v;
    for (int i = 0; i < len; i++) begin
      v = lo + $urandom_range(span);
      if (v > LEVELS - 1) v = LEVELS - 1;
      r.gray = v[PIX_W-1:0];
      r.eof = (i == len - 1);
      r.drain_first = drain && (i == 0);
      pix_queue.push_back(r);
    end
  endtask

  task automatic add_pixels(logic [PIX_W-1:0] vals[$]);
    pix_req_t r;
    foreach (vals[i]) begin
      r.gray = vals[i];
      r.eof = (i == vals.size() - 1);
      r.drain_first = 1'b0;
      pix_queue.push_back(r);
    end
  endtask

  // Histogram model and expected thresholds, updated on each accepted request
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) hist[i] = '0;
      pix_count = '0;
    end else if (in_valid && !in_stall) begin
      pix_taken++;
      if (hist[pixel] != '1) hist[pixel] = hist[pixel] + 1'b1;
      if (pix_count != '1) pix_count = pix_count + 1'b1;
      if (last) begin
        thr_expected.push_back(otsu_pick());
        for (int i = 0; i < LEVELS; i++) hist[i] = '0;
        pix_count = '0;
      end
    end
  end

  // Driver: hold a pending request, else load the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pix_queue.size() == 0 ||
          (pix_queue[0].drain_first && thr_expected.size() != 0) ||
          $urandom_range(99) < sender_idle_pct()) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        pixel <= pix_queue[0].gray;
        last <= pix_queue[0].eof;
        void'(pix_queue.pop_front());
      end
    end
  end

  // Receiver stall, with one long hold-off while pixels keep coming
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && pix_taken >= 400) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // Monitor and compare
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (thr_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected threshold %0d", threshold);
      end else begin
        if (threshold !== thr_expected[0]) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("frame %0d: threshold expected %0d actual %0d",
                     frames_done, thr_expected[0], threshold);
        end
        void'(thr_expected.pop_front());
        frames_done++;
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d pending pixels, %0d thresholds outstanding",
               pix_queue.size(), thr_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int len, lo, span, sel;
    int added;
    // Single pixel at each extreme, flat frame, two-level extremes, tie, all bits
    add_pixels('{8'd0});
    add_pixels('{8'd255});
    add_pixels('{8'd128, 8'd128, 8'd128, 8'd128, 8'd128});
    add_pixels('{8'd0, 8'd255});
    add_pixels('{8'd10, 8'd12, 8'd10, 8'd12});
    add_pixels('{8'd20, 8'd21, 8'd22, 8'd23});
    add_pixels('{8'haa, 8'h55, 8'hff, 8'h00, 8'h55, 8'haa});
    added = 0;
    while (added < RAND_PIX) begin
      len = $urandom_range(60, 1);
      sel = $urandom_range(99);
      if (sel < 4) begin
        lo = 0; span = LEVELS - 1;
      end else begin
        lo = $urandom_range(LEVELS - 1);
        span = $urandom_range(15);
      end
      add_frame(len, lo, span, added > RAND_PIX / 2 && added < RAND_PIX / 2 + 61);
      added += len;
    end
    total_reqs = pix_queue.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    wait (pix_queue.size() == 0 && !in_valid);
    wait (thr_expected.size() == 0);
    repeat (END_WAIT) @(posedge clk);
    $display("%0d pixels in %0d frames, narrow and full-range, under both stall mixes",
             pix_taken, frames_done);
    if (mismatches == 0 && thr_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
